[hw/rtl/tme_pkg.sv]
// ----------------------------------------------------------------------------
// Text to Morse encoder package
// Symbol codes, the Morse code table, character classification and the job
// record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package tme_pkg;

    localparam int MaxSyms    = 7;
    localparam int CntW       = 3;
    localparam int CodeW      = 5;
    localparam int NumCodes   = 36;
    localparam int IdxW       = 6;
    localparam int QueueDepth = 2;

    localparam logic [7:0] CharSpace  = 8'h20;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharOne    = 8'h31;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharLowerZ = 8'h7a;
    localparam logic [IdxW-1:0] IdxDigitOne = 6'd26;
    localparam logic [IdxW-1:0] IdxDigitZero = 6'd35;

    typedef enum logic [1:0] {
        SYM_DOT  = 2'd0,
        SYM_DASH = 2'd1,
        SYM_SEP  = 2'd2,
        SYM_GAP  = 2'd3
    } t_symbol;

    // Pattern is left aligned: bit CodeW-1 is the first symbol, 1 means dash.
    typedef struct packed {
        logic [CntW-1:0]  len;
        logic [CodeW-1:0] bits;
    } t_code;

    localparam t_code CodeTable [NumCodes] = '{
        '{3'd2, 5'b01000}, '{3'd4, 5'b10000}, '{3'd4, 5'b10100}, '{3'd3, 5'b10000},
        '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b11000}, '{3'd4, 5'b00000},
        '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b10100}, '{3'd4, 5'b01000},
        '{3'd2, 5'b11000}, '{3'd2, 5'b10000}, '{3'd3, 5'b11100}, '{3'd4, 5'b01100},
        '{3'd4, 5'b11010}, '{3'd3, 5'b01000}, '{3'd3, 5'b00000}, '{3'd1, 5'b10000},
        '{3'd3, 5'b00100}, '{3'd4, 5'b00010}, '{3'd3, 5'b01100}, '{3'd4, 5'b10010},
        '{3'd4, 5'b10110}, '{3'd4, 5'b11000},
        '{3'd5, 5'b01111}, '{3'd5, 5'b00111}, '{3'd5, 5'b00011}, '{3'd5, 5'b00001},
        '{3'd5, 5'b00000}, '{3'd5, 5'b10000}, '{3'd5, 5'b11000}, '{3'd5, 5'b11100},
        '{3'd5, 5'b11110}, '{3'd5, 5'b11111}
    };

    typedef struct packed {
        logic            is_code;
        logic            is_space;
        logic [IdxW-1:0] idx;
    } t_class;

    // One request worth of symbols, already laid out in emission order.
    typedef struct packed {
        t_symbol [MaxSyms-1:0] syms;
        logic [CntW-1:0]       count;
        logic                  last;
    } t_job;

    function automatic t_class classify(logic [7:0] c);
        t_class     r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= CharLowerA && c <= CharLowerZ) begin
            d = c - CharLowerA;
            r.is_code = 1'b1;
            r.idx     = d[IdxW-1:0];
        end else if (c >= CharOne && c <= CharNine) begin
            d = c - CharOne;
            r.is_code = 1'b1;
            r.idx     = d[IdxW-1:0] + IdxDigitOne;
        end else if (c == CharZero) begin
            r.is_code = 1'b1;
            r.idx     = IdxDigitZero;
        end else if (c == CharSpace) begin
            r.is_space = 1'b1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/tme_front.sv]
// ----------------------------------------------------------------------------
// Text to Morse encoder front part
// Accepts characters, classifies them and lays out the symbols of each one.
// ----------------------------------------------------------------------------
module tme_front import tme_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_text,
    output logic       o_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic   r_pending;
    logic   n_pending;
    logic   accept;
    logic   pre;
    t_class cls;
    t_code  code;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign cls     = classify(i_char_code);
    assign code    = cls.is_code ? CodeTable[cls.idx] : '0;
    assign pre     = r_pending && (i_char_code != CharSpace);

    always_comb begin
        logic [CntW-1:0] j;
        o_job      = '0;
        o_job.last = i_end_of_text;
        for (int k = 0; k < MaxSyms; k++) begin
            j = CntW'(k) - {{(CntW-1){1'b0}}, pre};
            o_job.syms[k] = SYM_DOT;
            if (pre && k == 0) begin
                o_job.syms[k] = SYM_SEP;
            end else if (cls.is_space) begin
                if (j == '0) begin
                    o_job.syms[k] = SYM_GAP;
                end else begin
                    o_job.syms[k] = SYM_SEP;
                end
            end else if (cls.is_code) begin
                if (j < code.len) begin
                    o_job.syms[k] = code.bits[CntW'(CodeW - 1) - j] ? SYM_DASH : SYM_DOT;
                end else begin
                    o_job.syms[k] = SYM_SEP;
                end
            end
        end
        o_job.count = {{(CntW-1){1'b0}}, pre};
        if (cls.is_space) begin
            o_job.count = o_job.count + CntW'(1) + {{(CntW-1){1'b0}}, i_end_of_text};
        end else if (cls.is_code) begin
            o_job.count = o_job.count + code.len + {{(CntW-1){1'b0}}, i_end_of_text};
        end
    end

    assign o_push    = accept && (o_job.count != '0);
    assign n_pending = accept ? (cls.is_code && !i_end_of_text) : r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
    end

endmodule

[hw/rtl/tme_queue.sv]
// ----------------------------------------------------------------------------
// Text to Morse encoder job queue
// Small first-in first-out store of symbol jobs between front and back.
// ----------------------------------------------------------------------------
module tme_queue import tme_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntQW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    t_job             r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntQW-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntQW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntQW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntQW'(1);
            end
        end
    end

endmodule

[hw/rtl/tme_back.sv]
// ----------------------------------------------------------------------------
// Text to Morse encoder back part
// Takes queued jobs and sends their symbols out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tme_back import tme_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_symbol,
    output logic       o_run_last,
    output logic       o_text_done
);

    t_job            r_job;
    logic            r_busy;
    logic [CntW-1:0] r_idx;
    logic            r_out_valid;
    logic [1:0]      r_symbol;
    logic            r_run_last;
    logic            r_text_done;
    logic            out_free;
    logic            emit;
    logic            final_slot;
    logic            load;

    assign out_free   = !r_out_valid || !i_stall;
    assign emit       = r_busy && out_free;
    assign final_slot = (r_idx == r_job.count - CntW'(1));
    assign load       = i_q_valid && (!r_busy || (emit && final_slot));
    assign o_pop      = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_symbol    <= r_job.syms[r_idx];
            r_run_last  <= final_slot;
            r_text_done <= final_slot && r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (final_slot) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + CntW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_run_last  = r_run_last;
    assign o_text_done = r_text_done;

endmodule

[hw/rtl/text_to_morse_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Text to Morse encoder
// Turns a stream of text characters into international Morse symbols.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_char_code, i_end_of_text
//  output    out        o_valid / i_stall    o_symbol, o_run_last, o_text_done
//
// The front part accepts one character request per cycle while the job queue
// has room. A character yields from zero to seven symbols, and the back part
// sends one symbol per cycle while the output is not stalled; a request with
// no symbols pushes no job into the queue. The symbol serialiser in the back
// part sets the rate. Reset is synchronous and active low; it clears the
// pending separator flag, the queue and the output register. A stall on the
// output fills the queue and then stalls the input; the input side never
// stalls the output.
//
module text_to_morse_encoder_unit import tme_pkg::*; #(
    parameter int QDepth = QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_symbol,
    output logic       o_run_last,
    output logic       o_text_done
);

    // Job records pass from the classifier to the serialiser through the queue,
    // so the serialiser can wait without holding up the classifier until it fills.
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job front_job;
    t_job back_job;

    tme_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_stall       (o_stall),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (front_job)
    );

    tme_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    // The serialiser keeps the current job and a slot counter, and loads the
    // next job in the cycle it sends the final slot: queued jobs run gap-free.
    tme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (back_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule
